// File: sv/plr_pkg.sv
// ----------------------------------------------------------------------------
// plr_pkg
// Shared constants, types and codes for the polygon region lookup block.
// ----------------------------------------------------------------------------
package plr_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int MAX_POLYGONS = 16;
  localparam int COORD_BITS   = 16;

  localparam int VA  = $clog2(MAX_VERTICES);      // vertex RAM address bits
  localparam int VCW = $clog2(MAX_VERTICES + 1);  // vertex count bits
  localparam int PCW = $clog2(MAX_POLYGONS + 1);  // polygon count bits
  localparam int DW  = COORD_BITS + 1;            // coordinate difference bits
  localparam int PW  = 2 * DW;                    // product bits

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DW-1:0]         diff_t;
  typedef logic signed [PW-1:0]         prod_t;

  // function codes of a request
  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  // status codes of a result
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_VERT_FULL = 2'd1;
  localparam logic [1:0] ST_POLY_FULL = 2'd2;

  // configuration registers
  localparam logic      REG_NO_REGION   = 1'b0;
  localparam logic [7:0] NO_REGION_RESET = 8'd255;

  // one polygon descriptor, held by a cell of the table chain
  typedef struct packed {
    logic [VCW-1:0] first;
    logic [VCW-1:0] count;
    logic [7:0]     region;
  } plr_poly_t;

  // one edge handed to the crossing test
  typedef struct packed {
    logic   valid;
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
  } plr_edge_t;

endpackage

// File: sv/plr_ram.sv
// ----------------------------------------------------------------------------
// plr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module plr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/plr_cell.sv
// ----------------------------------------------------------------------------
// plr_cell
// One polygon table cell: holds a descriptor, loads it on the append that
// closes a polygon and hands it to its neighbor when the table chain rotates.
// ----------------------------------------------------------------------------
module plr_cell (
  input  logic              clk,
  input  logic              load,
  input  plr_pkg::plr_poly_t load_data,
  input  logic              shift,
  input  plr_pkg::plr_poly_t shift_in,
  output plr_pkg::plr_poly_t data
);

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end else if (shift) begin
      data <= shift_in;
    end
  end

endmodule

// File: sv/plr_edge.sv
// ----------------------------------------------------------------------------
// plr_edge
// Two-stage crossing test of one edge against the query point, with the
// running crossing parity of the current polygon.
// ----------------------------------------------------------------------------
module plr_edge (
  input  logic              clk,
  input  logic              rst,
  input  logic              clr,
  input  plr_pkg::plr_edge_t edge_in,
  input  plr_pkg::coord_t   qx,
  input  plr_pkg::coord_t   qy,
  output logic              parity
);

  plr_pkg::coord_t ylo, yhi, xhi;
  plr_pkg::diff_t  dxq, dy, dyq, dx;
  logic            cond_a, vert_a, dpos_a;

  logic            valid_b, cond_b, vert_b, dpos_b;
  plr_pkg::prod_t  p1, p2;
  logic            hit;

  always_comb begin
    ylo    = (edge_in.y1 < edge_in.y2) ? edge_in.y1 : edge_in.y2;
    yhi    = (edge_in.y1 < edge_in.y2) ? edge_in.y2 : edge_in.y1;
    xhi    = (edge_in.x1 < edge_in.x2) ? edge_in.x2 : edge_in.x1;
    dxq    = plr_pkg::DW'(qx) - plr_pkg::DW'(edge_in.x1);
    dy     = plr_pkg::DW'(edge_in.y2) - plr_pkg::DW'(edge_in.y1);
    dyq    = plr_pkg::DW'(qy) - plr_pkg::DW'(edge_in.y1);
    dx     = plr_pkg::DW'(edge_in.x2) - plr_pkg::DW'(edge_in.x1);
    cond_a = (qy > ylo) && (qy <= yhi) && (qx <= xhi) && (edge_in.y1 != edge_in.y2);
    vert_a = (edge_in.x1 == edge_in.x2);
    dpos_a = (edge_in.y2 > edge_in.y1);
  end

  // stage A: conditions and the two cross products
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b <= 1'b0;
    end else begin
      valid_b <= edge_in.valid;
    end
    cond_b <= cond_a;
    vert_b <= vert_a;
    dpos_b <= dpos_a;
    p1     <= dxq * dy;
    p2     <= dyq * dx;
  end

  // qx left of or on the intersection, compared without division
  assign hit = cond_b && (vert_b || (dpos_b ? (p1 <= p2) : (p1 >= p2)));

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      parity <= 1'b0;
    end else if (valid_b && hit) begin
      parity <= ~parity;
    end
  end

endmodule

// File: sv/polygon_region_lookup_core.sv
// ----------------------------------------------------------------------------
// polygon_region_lookup_core
// Polygon table with crossing-number point lookup returning the smallest
// containing region id.
// ----------------------------------------------------------------------------
// channel   | direction | handshake            | payload
// request   | in        | req_valid/req_ready  | func coord_x coord_y region_id last_vertex
// result    | out       | res_valid/res_ready  | found_region inside_res status
// config    | in        | APB psel/penable     | paddr pwdata prdata
//
// Clear and append give their result in the cycle after they are accepted.
// A query rotates the 16-cell polygon table once: it skips each unused or
// empty slot and walks the vertices of each stored polygon, bounded by the
// single vertex RAM read port (one vertex a cycle).
// Reset is synchronous; the vertex RAM and the table cells are not cleared.
// A stalled result holds and blocks new requests until it is taken.
// ----------------------------------------------------------------------------
module polygon_region_lookup_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  logic [1:0]             func,
  input  plr_pkg::coord_t        coord_x,
  input  plr_pkg::coord_t        coord_y,
  input  logic [7:0]             region_id,
  input  logic                   last_vertex,
  output logic                   res_valid,
  input  logic                   res_ready,
  output logic [7:0]             found_region,
  output logic                   inside_res,
  output logic [1:0]             status,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  typedef enum logic [2:0] {
    S_IDLE, S_POLY, S_WALK, S_CLOSE, S_DRAIN, S_EVAL, S_OUT
  } state_t;

  state_t state;

  logic [7:0]               no_region_code;
  logic [plr_pkg::VCW-1:0]  vertices_used, open_start;
  logic [plr_pkg::PCW-1:0]  polygons_used, poly_idx;
  plr_pkg::coord_t          qx, qy;
  logic [7:0]               best;
  logic                     any;

  logic [plr_pkg::VCW-1:0]  ptr, issue_cnt;
  logic                     pend, pend_last, have_first;
  plr_pkg::coord_t          fx, fy, px, py;

  logic                     accept, do_append, poly_full, vert_full, close;
  logic                     res_load;
  logic [plr_pkg::VCW-1:0]  vu_next;
  logic                     shift, rd_en, parity, clr_par;
  logic [2*plr_pkg::COORD_BITS-1:0] rd_data;
  plr_pkg::coord_t          rx, ry;
  plr_pkg::plr_edge_t       edge_in;
  plr_pkg::plr_poly_t       new_poly, head;
  plr_pkg::plr_poly_t       cells [plr_pkg::MAX_POLYGONS];

  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == plr_pkg::REG_NO_REGION) ? {24'd0, no_region_code} : 32'd0;
  assign req_ready = (state == S_IDLE) && (!res_valid || res_ready);
  assign accept    = req_valid && req_ready;

  assign poly_full = (polygons_used == plr_pkg::PCW'(plr_pkg::MAX_POLYGONS));
  assign vert_full = (vertices_used == plr_pkg::VCW'(plr_pkg::MAX_VERTICES));
  assign do_append = accept && (func == plr_pkg::FUNC_APPEND) && !poly_full;
  assign close     = do_append && last_vertex;
  assign vu_next   = vertices_used + plr_pkg::VCW'(!vert_full);

  // a result is loaded by any non-query request or by a finished query
  assign res_load  = (accept && func != plr_pkg::FUNC_QUERY) ||
                     (state == S_OUT && (!res_valid || res_ready));

  assign new_poly.first  = open_start;
  assign new_poly.count  = vu_next - open_start;
  assign new_poly.region = region_id;

  assign head = cells[0];
  assign rx   = rd_data[2*plr_pkg::COORD_BITS-1:plr_pkg::COORD_BITS];
  assign ry   = rd_data[plr_pkg::COORD_BITS-1:0];

  plr_ram #(
    .WIDTH(2 * plr_pkg::COORD_BITS),
    .DEPTH(plr_pkg::MAX_VERTICES)
  ) u_vram (
    .clk     (clk),
    .wr_en   (do_append && !vert_full),
    .wr_addr (vertices_used[plr_pkg::VA-1:0]),
    .wr_data ({coord_x, coord_y}),
    .rd_en   (rd_en),
    .rd_addr (ptr[plr_pkg::VA-1:0]),
    .rd_data (rd_data)
  );

  // polygon table: a ring of cells rotating toward cell 0
  for (genvar k = 0; k < plr_pkg::MAX_POLYGONS; k++) begin : g_cell
    plr_cell u_cell (
      .clk       (clk),
      .load      (close && (polygons_used == plr_pkg::PCW'(k))),
      .load_data (new_poly),
      .shift     (shift),
      .shift_in  (cells[(k + 1) % plr_pkg::MAX_POLYGONS]),
      .data      (cells[k])
    );
  end

  always_comb begin
    edge_in.valid = 1'b0;
    edge_in.x1    = px;
    edge_in.y1    = py;
    edge_in.x2    = rx;
    edge_in.y2    = ry;
    if (state == S_WALK && pend && have_first) begin
      edge_in.valid = 1'b1;
    end else if (state == S_CLOSE) begin
      edge_in.valid = 1'b1;
      edge_in.x2    = fx;
      edge_in.y2    = fy;
    end
  end

  plr_edge u_edge (
    .clk     (clk),
    .rst     (rst),
    .clr     (clr_par),
    .edge_in (edge_in),
    .qx      (qx),
    .qy      (qy),
    .parity  (parity)
  );

  assign rd_en   = (state == S_WALK) && (issue_cnt != '0);
  assign clr_par = (state == S_POLY);
  assign shift   = (state == S_EVAL) ||
                   (state == S_POLY && poly_idx != plr_pkg::PCW'(plr_pkg::MAX_POLYGONS) &&
                    (poly_idx >= polygons_used || head.count == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      no_region_code <= plr_pkg::NO_REGION_RESET;
      vertices_used  <= '0;
      polygons_used  <= '0;
      open_start     <= '0;
      res_valid      <= 1'b0;
      pend           <= 1'b0;
      pend_last      <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == plr_pkg::REG_NO_REGION) begin
        no_region_code <= pwdata[7:0];
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      pend      <= rd_en;
      pend_last <= rd_en && (issue_cnt == plr_pkg::VCW'(1));
      case (state)
        S_IDLE: begin
          if (accept) begin
            found_region <= 8'd0;
            inside_res   <= 1'b0;
            status       <= plr_pkg::ST_OK;
            case (func)
              plr_pkg::FUNC_CLEAR: begin
                vertices_used <= '0;
                polygons_used <= '0;
                open_start    <= '0;
              end
              plr_pkg::FUNC_APPEND: begin
                if (poly_full) begin
                  status <= plr_pkg::ST_POLY_FULL;
                end else begin
                  if (vert_full) begin
                    status <= plr_pkg::ST_VERT_FULL;
                  end
                  vertices_used <= vu_next;
                  if (last_vertex) begin
                    polygons_used <= polygons_used + plr_pkg::PCW'(1);
                    open_start    <= vu_next;
                  end
                end
              end
              plr_pkg::FUNC_QUERY: begin
                qx       <= coord_x;
                qy       <= coord_y;
                poly_idx <= '0;
                any      <= 1'b0;
                best     <= 8'd0;
                state    <= S_POLY;
              end
              default: ;
            endcase
          end
        end
        S_POLY: begin
          if (poly_idx == plr_pkg::PCW'(plr_pkg::MAX_POLYGONS)) begin
            state <= S_OUT;
          end else if (shift) begin
            poly_idx <= poly_idx + plr_pkg::PCW'(1);
          end else begin
            ptr        <= head.first;
            issue_cnt  <= head.count;
            have_first <= 1'b0;
            state      <= S_WALK;
          end
        end
        S_WALK: begin
          if (rd_en) begin
            ptr       <= ptr + plr_pkg::VCW'(1);
            issue_cnt <= issue_cnt - plr_pkg::VCW'(1);
          end
          if (pend) begin
            px <= rx;
            py <= ry;
            if (!have_first) begin
              fx         <= rx;
              fy         <= ry;
              have_first <= 1'b1;
            end
            if (pend_last) begin
              state <= S_CLOSE;
            end
          end
        end
        S_CLOSE: state <= S_DRAIN;
        S_DRAIN: state <= S_EVAL;
        S_EVAL: begin
          if (parity && (!any || head.region < best)) begin
            best <= head.region;
          end
          any      <= any | parity;
          poly_idx <= poly_idx + plr_pkg::PCW'(1);
          state    <= S_POLY;
        end
        S_OUT: begin
          // hold until the result slot is free
          if (!res_valid || res_ready) begin
            found_region <= any ? best : no_region_code;
            inside_res   <= any;
            status       <= plr_pkg::ST_OK;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/plr_checker.sv
// ----------------------------------------------------------------------------
// plr_checker
// Port-level checks of the polygon region lookup core, bound to the top.
// ----------------------------------------------------------------------------
module plr_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [7:0]  found_region,
  input logic        inside_res,
  input logic [1:0]  status
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(found_region) && $stable(status))
    else $error("result changed while stalled");

  a_no_req_when_blocked: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !req_ready)
    else $error("request taken while result stalled");

  a_drop_has_no_hit: assert property (@(posedge clk) disable iff (rst)
    res_valid && status != plr_pkg::ST_OK |-> found_region == 8'd0 && !inside_res)
    else $error("dropped append reports a region");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> status == plr_pkg::ST_OK || status == plr_pkg::ST_VERT_FULL ||
                  status == plr_pkg::ST_POLY_FULL)
    else $error("unknown status code");

endmodule

bind polygon_region_lookup_core plr_checker u_plr_checker (.*);
